// ===== rtl/core/vn_pkg.sv =====
// Shared widths for the four-component vector normalizer.
`default_nettype none
package vn_pkg;
    localparam int unsigned COMP_W  = 32;
    localparam int unsigned SQ_W    = 63;
    localparam int unsigned SUM_W   = 65;
    localparam int unsigned ROOT_W  = 33;
    localparam int unsigned LANES   = 4;
    localparam int unsigned SQ_LAT  = 2;
    localparam int unsigned SUM_LAT = 2;
endpackage
`default_nettype wire

// ===== rtl/core/vn_sq_lane.sv =====
// One lane: absolute value and square of a signed component.
`default_nettype none
module vn_sq_lane (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic signed [vn_pkg::COMP_W-1:0] comp,
    output logic [vn_pkg::COMP_W-1:0]         mag,
    output logic                              neg,
    output logic [vn_pkg::SQ_W-1:0]           sq
);
    import vn_pkg::*;

    logic [COMP_W-1:0] mag_reg, mag2_reg;
    logic              neg_reg, neg2_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [2*COMP_W-1:0] prod;

    assign prod = mag_reg * mag_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= comp[COMP_W-1] ? COMP_W'(-comp) : COMP_W'(comp);
            neg_reg  <= comp[COMP_W-1];
            mag2_reg <= mag_reg;
            neg2_reg <= neg_reg;
            sq_reg   <= prod[SQ_W-1:0];  // at most 2^62
        end
    end

    assign mag = mag2_reg;
    assign neg = neg2_reg;
    assign sq  = sq_reg;
endmodule
`default_nettype wire

// ===== rtl/core/vn_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module vn_sqrt (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [vn_pkg::SUM_W-1:0]  radicand,
    output logic [vn_pkg::ROOT_W-1:0]      root
);
    import vn_pkg::*;

    logic [SUM_W-1:0]  rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int unsigned BIT = ROOT_W - 1 - k;
        logic [SUM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W:0]    trial;
        if (k == 0) begin : g_first
            assign rem_in  = radicand;
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end
        // low root bits are still zero, so the two terms never overlap
        assign trial = ((SUM_W+1)'(root_in) << (BIT + 1)) + ((SUM_W+1)'(1) << (2 * BIT));

        always_ff @(posedge aclk) begin
            if (en) begin
                if ({1'b0, rem_in} >= trial) begin
                    rem_reg[k]  <= rem_in - trial[SUM_W-1:0];
                    root_reg[k] <= root_in | (ROOT_W'(1) << BIT);
                end else begin
                    rem_reg[k]  <= rem_in;
                    root_reg[k] <= root_in;
                end
            end
        end
    end

    assign root = root_reg[ROOT_W-1];
endmodule
`default_nettype wire

// ===== rtl/core/vn_div_lane.sv =====
// Pipelined restoring divider: (mag << FRAC_BITS) / length, signed result.
`default_nettype none
module vn_div_lane #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [vn_pkg::COMP_W-1:0] mag,
    input  wire logic                      neg,
    input  wire logic [vn_pkg::ROOT_W-1:0] len,
    output logic [vn_pkg::COMP_W-1:0]      unit
);
    import vn_pkg::*;

    localparam int unsigned QW = FRAC_BITS + 1;

    logic [ROOT_W-1:0] rem_reg [0:QW-1];
    logic [ROOT_W-1:0] len_reg [0:QW-1];
    logic [QW-1:0]     q_reg   [0:QW-1];
    logic              neg_reg [0:QW-1];
    logic [COMP_W-1:0] unit_reg;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [ROOT_W-1:0] rem_in, len_in;
        logic [QW-1:0]     q_in;
        logic              neg_in;
        logic [ROOT_W:0]   shifted;
        logic [ROOT_W+1:0] diff;
        if (k == 0) begin : g_first
            // quotient fits QW bits, so the upper dividend bits form the start remainder
            assign rem_in  = ROOT_W'(mag >> 1);
            assign len_in  = len;
            assign q_in    = '0;
            assign neg_in  = neg;
            assign shifted = {rem_in, mag[0]};
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign len_in  = len_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign neg_in  = neg_reg[k-1];
            assign shifted = {rem_in, 1'b0};
        end
        assign diff = {1'b0, shifted} - {2'b00, len_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                len_reg[k] <= len_in;
                neg_reg[k] <= neg_in;
                if (!diff[ROOT_W+1]) begin
                    rem_reg[k] <= diff[ROOT_W-1:0];
                    q_reg[k]   <= {q_in[QW-2:0], 1'b1};
                end else begin
                    rem_reg[k] <= shifted[ROOT_W-1:0];
                    q_reg[k]   <= {q_in[QW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        if (neg_reg[QW-1]) unit_reg = COMP_W'(-COMP_W'(q_reg[QW-1]));
        else               unit_reg = COMP_W'(q_reg[QW-1]);
    end

    assign unit = unit_reg;
endmodule
`default_nettype wire

// ===== rtl/core/vector4_normalize_top.sv =====
// Top level: four-component vector normalizer, fully pipelined.
//
//  channel | dir | tdata (low bit up)                               | tuser
//  s_      | in  | comp_w, comp_x, comp_y, comp_z (4 x 32)          | -
//  m_      | out | unit_w, unit_x, unit_y, unit_z, magnitude, pad   | zero_vector
//
// One request per cycle while the output is not stalled; the stages are abs,
// square, the sum tree, the square root (one bit per stage), the dividers
// and an output register. The root pipeline and four divider lanes run deepest.
// aresetn clears the valid bits only; the datapath carries no reset.
// A stalled result holds the whole pipeline; s_tready follows the output slot.
`default_nettype none
module vector4_normalize_top #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // comp_w, comp_x, comp_y, comp_z
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [167:0]      m_tdata,   // unit_w, unit_x, unit_y, unit_z, magnitude, zeros
    output logic [0:0]        m_tuser    // zero_vector
);
    import vn_pkg::*;

    localparam int unsigned QW      = FRAC_BITS + 1;
    localparam int unsigned ALIGN   = SUM_LAT + ROOT_W;           // lane data wait for root
    localparam int unsigned LAT     = SQ_LAT + ALIGN + QW + 1;

    logic en;
    logic vld_reg [0:LAT-1];

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // square lanes
    logic [COMP_W-1:0] mag  [0:LANES-1];
    logic              neg  [0:LANES-1];
    logic [SQ_W-1:0]   sq   [0:LANES-1];

    for (genvar l = 0; l < LANES; l++) begin : g_sq
        vn_sq_lane u_sq (
            .aclk (aclk),
            .en   (en),
            .comp (s_tdata[l*COMP_W +: COMP_W]),
            .mag  (mag[l]),
            .neg  (neg[l]),
            .sq   (sq[l])
        );
    end

    // merge: two-level sum tree
    logic [SQ_W:0]    pair0_reg, pair1_reg;
    logic [SUM_W-1:0] total_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pair0_reg <= (SQ_W+1)'(sq[0]) + (SQ_W+1)'(sq[1]);
            pair1_reg <= (SQ_W+1)'(sq[2]) + (SQ_W+1)'(sq[3]);
            total_reg <= SUM_W'(pair0_reg) + SUM_W'(pair1_reg);
        end
    end

    logic [ROOT_W-1:0] root;

    vn_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (total_reg),
        .root     (root)
    );

    // lane data wait alongside the sum and root
    logic [COMP_W-1:0] mag_dly_reg [0:LANES-1][0:ALIGN-1];
    logic              neg_dly_reg [0:LANES-1][0:ALIGN-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                mag_dly_reg[l][0] <= mag[l];
                neg_dly_reg[l][0] <= neg[l];
                for (int i = 1; i < ALIGN; i++) begin
                    mag_dly_reg[l][i] <= mag_dly_reg[l][i-1];
                    neg_dly_reg[l][i] <= neg_dly_reg[l][i-1];
                end
            end
        end
    end

    logic [COMP_W-1:0] unit [0:LANES-1];

    for (genvar l = 0; l < LANES; l++) begin : g_div
        vn_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
            .aclk (aclk),
            .en   (en),
            .mag  (mag_dly_reg[l][ALIGN-1]),
            .neg  (neg_dly_reg[l][ALIGN-1]),
            .len  (root),
            .unit (unit[l])
        );
    end

    // length rides next to the dividers
    logic [ROOT_W-1:0] len_dly_reg [0:QW-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            len_dly_reg[0] <= root;
            for (int i = 1; i < QW; i++) len_dly_reg[i] <= len_dly_reg[i-1];
        end
    end

    // output slot; a zero length means all inputs were zero, so units are zero
    logic [167:0] out_reg;
    logic [167:0] out_next;
    logic         zero_reg;
    logic         is_zero;

    assign is_zero = (len_dly_reg[QW-1] == '0);

    always_comb begin
        out_next = '0;
        for (int l = 0; l < LANES; l++) begin
            out_next[l*COMP_W +: COMP_W] = is_zero ? '0 : unit[l];
        end
        out_next[LANES*COMP_W +: ROOT_W] = len_dly_reg[QW-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg <= is_zero;
            out_reg  <= out_next;
        end
    end

    assign m_tdata = out_reg;
    assign m_tuser = zero_reg;
endmodule
`default_nettype wire
